// ----- rtl/fwme_pkg.sv -----
// Shared types, constants and codes of the match-extract queue.
`timescale 1ns / 1ps
package fwme_pkg;

    localparam int DEPTH      = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int OCC_W      = IDX_W + 1;
    localparam int DATA_BITS  = 16;
    localparam int COUNT_BITS = 8;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CAP_W      = 6;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EXTRACT = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // register index of the capacity register
    localparam logic REG_CAPACITY = 1'b0;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [DATA_BITS-1:0]  cust_data;
        logic [COUNT_BITS-1:0] cust_count;
        logic [COUNT_BITS-1:0] wanted_count;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [DATA_BITS-1:0]  out_data;
        logic [COUNT_BITS-1:0] out_count;
        logic [OCC_W-1:0]      occupancy;
    } t_out;

    typedef struct packed {
        logic [DATA_BITS-1:0]  data;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

endpackage

// ----- rtl/fifo_with_match_extract.sv -----
// Top level: order-preserving queue with extract-by-count and APB capacity register.
// Push, refused operations and the no-op register their result in the cycle after
//   acceptance; a pop reads the store first (S_POP); an extract searches (S_SEARCH),
//   then closes the gap (S_SHIFT). One push or no-op per cycle while results are popped;
//   the engine takes one request at a time, one store read or one move per cycle.
// Reset (synchronous, active low): queue empty, pointers at zero, capacity 32; the entry
//   store itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module fifo_with_match_extract (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request side
    input  logic                          push,
    output logic                          full,
    input  fwme_pkg::t_in                 i_push_item,
    // result side
    output logic                          empty,
    input  logic                          pop,
    output fwme_pkg::t_out                o_pop_item,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fwme_pkg::APB_AW-1:0]   paddr,
    input  logic [fwme_pkg::APB_DW-1:0]   pwdata,
    output logic [fwme_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import fwme_pkg::*;

    logic [CAP_W-1:0] r_capacity;
    logic [OCC_W-1:0] eff_cap;
    logic             cfg_wr;
    logic             req_valid;
    logic             req_take;
    logic             res_valid;
    t_in              req;

    // Register index is the top address bit; addresses with it set are ignored.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr && (paddr[APB_AW-1] == REG_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[APB_AW-1] == REG_CAPACITY) ?
                    {{(APB_DW-CAP_W){1'b0}}, r_capacity} : '0;

    // Capacity above the store depth saturates; zero refuses every push.
    assign eff_cap = (r_capacity > CAP_W'(DEPTH)) ? OCC_W'(DEPTH) : OCC_W'(r_capacity);

    // Front: requests wait here so the input side keeps moving while the
    // engine is busy with a long extract or the result is still held.
    fwme_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_push_item),
        .o_valid (req_valid),
        .o_item  (req),
        .i_take  (req_take)
    );

    // Back: one request at a time; the result register is the output stage.
    fwme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_take  (req_take),
        .i_eff_cap   (eff_cap),
        .o_res_valid (res_valid),
        .o_res       (o_pop_item),
        .i_res_pop   (pop)
    );

    assign empty = !res_valid;

endmodule

// ----- rtl/fwme_front.sv -----
// Front end: two-slot request queue between the input port and the engine.
`timescale 1ns / 1ps
module fwme_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  fwme_pkg::t_in i_item,
    output logic          o_valid,
    output fwme_pkg::t_in o_item,
    input  logic          i_take
);
    import fwme_pkg::*;

    t_in        r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       wr_en;
    logic       rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- rtl/fwme_back.sv -----
// Back end: entry store, head/tail pointers and the pop/extract sequencer.
`timescale 1ns / 1ps
module fwme_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  fwme_pkg::t_in                i_req,
    output logic                         o_req_take,
    input  logic [fwme_pkg::OCC_W-1:0]   i_eff_cap,
    output logic                         o_res_valid,
    output fwme_pkg::t_out               o_res,
    input  logic                         i_res_pop
);
    import fwme_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_POP    = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_SHIFT  = 2'd3;

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    logic [1:0]            r_state, n_state;
    logic [IDX_W-1:0]      r_head, n_head;
    logic [IDX_W-1:0]      r_tail, n_tail;
    logic [OCC_W-1:0]      r_total, n_total;
    logic [IDX_W-1:0]      r_pos, n_pos;
    logic [IDX_W-1:0]      r_k, n_k;
    logic [COUNT_BITS-1:0] r_want, n_want;
    t_entry                r_found, n_found;
    logic                  r_res_valid, n_res_valid;
    t_out                  r_res, n_res;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic             slot_free;
    logic [OCC_W-1:0] k_plus1;
    logic [OCC_W-1:0] k_plus2;

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign slot_free   = !r_res_valid || i_res_pop;
    assign o_req_take  = (r_state == S_IDLE) && i_req_valid && slot_free;
    assign k_plus1     = {1'b0, r_k} + OCC_W'(1);
    assign k_plus2     = {1'b0, r_k} + OCC_W'(2);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_total     = r_total;
        n_pos       = r_pos;
        n_k         = r_k;
        n_want      = r_want;
        n_found     = r_found;
        n_res_valid = r_res_valid && !i_res_pop;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = r_tail;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (o_req_take) begin
                    unique case (i_req.func)
                        FUNC_PUSH: begin
                            n_res_valid = 1'b1;
                            if (r_total >= i_eff_cap) begin
                                n_res = '{ST_FULL, '0, '0, r_total};
                            end else begin
                                mem_we    = 1'b1;
                                mem_wdata = '{i_req.cust_data, i_req.cust_count};
                                n_tail    = r_tail + IDX_W'(1);
                                n_total   = r_total + OCC_W'(1);
                                n_res     = '{ST_OK, '0, '0, r_total + OCC_W'(1)};
                            end
                        end
                        FUNC_POP: begin
                            if (r_total == '0) begin
                                n_res_valid = 1'b1;
                                n_res       = '{ST_EMPTY, '0, '0, r_total};
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_POP;
                            end
                        end
                        FUNC_EXTRACT: begin
                            if (r_total == '0) begin
                                n_res_valid = 1'b1;
                                n_res       = '{ST_NOT_FOUND, '0, '0, r_total};
                            end else begin
                                mem_re  = 1'b1;
                                n_pos   = r_head;
                                n_k     = '0;
                                n_want  = i_req.wanted_count;
                                n_state = S_SEARCH;
                            end
                        end
                        FUNC_NOP: begin
                            n_res_valid = 1'b1;
                            n_res       = '{ST_OK, '0, '0, r_total};
                        end
                        default: begin
                            n_res_valid = 1'b1;
                            n_res       = '{ST_OK, '0, '0, r_total};
                        end
                    endcase
                end
            end
            S_POP: begin
                n_res_valid = 1'b1;
                n_res       = '{ST_OK, r_rd.data, r_rd.count, r_total - OCC_W'(1)};
                n_head      = r_head + IDX_W'(1);
                n_total     = r_total - OCC_W'(1);
                n_state     = S_IDLE;
            end
            S_SEARCH: begin
                if (r_rd.count == r_want) begin
                    n_found = r_rd;
                    if (k_plus1 < r_total) begin
                        mem_re    = 1'b1;
                        mem_raddr = r_pos + IDX_W'(1);
                        n_state   = S_SHIFT;
                    end else begin
                        n_res_valid = 1'b1;
                        n_res       = '{ST_OK, r_rd.data, r_rd.count, r_total - OCC_W'(1)};
                        n_tail      = r_tail - IDX_W'(1);
                        n_total     = r_total - OCC_W'(1);
                        n_state     = S_IDLE;
                    end
                end else if (k_plus1 < r_total) begin
                    // step on to the next entry, read issued one ahead
                    mem_re    = 1'b1;
                    mem_raddr = r_pos + IDX_W'(1);
                    n_pos     = r_pos + IDX_W'(1);
                    n_k       = r_k + IDX_W'(1);
                end else begin
                    n_res_valid = 1'b1;
                    n_res       = '{ST_NOT_FOUND, '0, '0, r_total};
                    n_state     = S_IDLE;
                end
            end
            S_SHIFT: begin
                // close the gap: r_rd holds the entry one place behind r_pos
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_rd;
                n_pos     = r_pos + IDX_W'(1);
                n_k       = r_k + IDX_W'(1);
                if (k_plus2 < r_total) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_pos + IDX_W'(2);
                end else begin
                    n_res_valid = 1'b1;
                    n_res       = '{ST_OK, r_found.data, r_found.count, r_total - OCC_W'(1)};
                    n_tail      = r_tail - IDX_W'(1);
                    n_total     = r_total - OCC_W'(1);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_total     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_total     <= n_total;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_k     <= n_k;
        r_want  <= n_want;
        r_found <= n_found;
        r_res   <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

endmodule
